@@ hw/rtl/sskms_pkg.sv @@
// ----------------------------------------------------------------------------
// sskms_pkg
// Shared types, codes and helpers for the splice site k-mer max score unit.
// ----------------------------------------------------------------------------
package sskms_pkg;

	// Item commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_BASE = 1'b1;

	// ASCII characters that carry a nonzero base code
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;
	localparam logic [7:0] CHAR_T = 8'h54;

	// 2-bit base codes
	localparam logic [1:0] CODE_OTHER = 2'd0;
	localparam logic [1:0] CODE_C     = 2'd1;
	localparam logic [1:0] CODE_G     = 2'd2;
	localparam logic [1:0] CODE_T     = 2'd3;

	// Field widths fixed by the interface
	localparam int INDEX_W = 18;
	localparam int VALUE_W = 16;
	localparam int CHAR_W  = 8;

	typedef struct packed {
		logic                      command;
		logic [INDEX_W-1:0]        table_index;
		logic signed [VALUE_W-1:0] score_value;
		logic [CHAR_W-1:0]         base_char;
		logic                      last;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] best_score;
		logic                      window_found;
	} out_item_t;

	// Control carried alongside a base item into the compare stage
	typedef struct packed {
		logic valid;  // base item in stage
		logic hit;    // full window, table read is meaningful
		logic last;   // final base of the sequence
	} s1_ctrl_t;

	function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] ch);
		logic [1:0] code;
		case (ch)
			CHAR_C:  code = CODE_C;
			CHAR_G:  code = CODE_G;
			CHAR_T:  code = CODE_T;
			default: code = CODE_OTHER;
		endcase
		return code;
	endfunction

endpackage

@@ hw/rtl/sskms_score_mem.sv @@
// ----------------------------------------------------------------------------
// sskms_score_mem
// Score table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sskms_score_mem #(
	parameter int ADDR_W = 18,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/sskms_window.sv @@
// ----------------------------------------------------------------------------
// sskms_window
// Front stage: decodes items, shifts bases into the window, drives the
// table write and read ports and hands base items to the compare stage.
// ----------------------------------------------------------------------------
module sskms_window
	import sskms_pkg::*;
#(
	parameter int WINDOW_LEN = 9,
	parameter int SCORE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              item,
	input  logic                  accept,
	input  logic                  hold,
	output logic                  wr_en,
	output logic [2*WINDOW_LEN-1:0] wr_addr,
	output logic [SCORE_BITS-1:0] wr_data,
	output logic                  rd_en,
	output logic [2*WINDOW_LEN-1:0] rd_addr,
	output s1_ctrl_t              ctrl_s1
);

	localparam int IDX_W  = 2 * WINDOW_LEN;
	localparam int SEEN_W = $clog2(WINDOW_LEN + 1);
	localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(WINDOW_LEN);

	logic [IDX_W-1:0]  window_q;
	logic [SEEN_W-1:0] seen_q;
	logic [IDX_W-1:0]  window_next;
	logic [SEEN_W-1:0] seen_next;
	logic              is_base;
	logic              is_load;
	logic signed [SCORE_BITS-1:0] value_ext;

	assign is_base = accept && (item.command == CMD_BASE);
	assign is_load = accept && (item.command == CMD_LOAD);

	// new window: oldest base drops off the top
	assign window_next = IDX_W'({window_q, base_code(item.base_char)});
	assign seen_next   = (seen_q == SEEN_FULL) ? seen_q : seen_q + SEEN_W'(1);

	// table write for load items
	assign value_ext = SCORE_BITS'(item.score_value);
	assign wr_en     = is_load;
	assign wr_addr   = IDX_W'(item.table_index);
	assign wr_data   = value_ext;

	// table read for base items
	assign rd_en   = is_base;
	assign rd_addr = window_next;

	// per-sequence window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
		end else if (is_base) begin
			if (item.last) begin
				window_q <= '0;
				seen_q   <= '0;
			end else begin
				window_q <= window_next;
				seen_q   <= seen_next;
			end
		end
	end

	// hand-off to compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (!hold) begin
			ctrl_s1.valid <= is_base;
			ctrl_s1.hit   <= seen_next == SEEN_FULL;
			ctrl_s1.last  <= item.last;
		end
	end

endmodule

@@ hw/rtl/sskms_max_track.sv @@
// ----------------------------------------------------------------------------
// sskms_max_track
// Compare stage: keeps the strict running maximum over table reads and
// holds the finished result in an output register.
// ----------------------------------------------------------------------------
module sskms_max_track
	import sskms_pkg::*;
#(
	parameter int SCORE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  s1_ctrl_t              ctrl_s1,
	input  logic [SCORE_BITS-1:0] rd_data,
	input  logic                  result_stall,
	output logic                  hold,
	output logic                  result_valid,
	output out_item_t             result
);

	localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

	logic signed [SCORE_BITS-1:0] max_q;
	logic                         any_q;
	logic signed [SCORE_BITS-1:0] rd_score;
	logic signed [SCORE_BITS-1:0] max_next;
	logic                         any_next;
	logic                         retire;
	logic                         out_valid_q;
	out_item_t                    out_q;

	// a final base waits while the output register is full and stalled
	assign hold   = ctrl_s1.valid && ctrl_s1.last && out_valid_q && result_stall;
	assign retire = ctrl_s1.valid && !hold;

	assign rd_score = rd_data;
	assign max_next = (ctrl_s1.hit && (rd_score > max_q)) ? rd_score : max_q;
	assign any_next = any_q || ctrl_s1.hit;

	// running maximum, cleared after the final base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= SCORE_MIN;
			any_q <= 1'b0;
		end else if (retire) begin
			if (ctrl_s1.last) begin
				max_q <= SCORE_MIN;
				any_q <= 1'b0;
			end else begin
				max_q <= max_next;
				any_q <= any_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire && ctrl_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && ctrl_s1.last) begin
			out_q.best_score   <= VALUE_W'(max_next);
			out_q.window_found <= any_next;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

@@ hw/rtl/splice_site_kmer_max_score_unit.sv @@
// A final base item's result passes the table read register and then the compare
// stage's output register. Throughput: one item per cycle, loads and bases alike,
// while item_stall is low; the path is the table read register followed by the compare stage.
// item_stall rises only while a result sits stalled and the next final base waits.
// Reset clears the window, base count, running maximum and output valid flag;
// the score table is not cleared and holds nothing meaningful until written.
// ----------------------------------------------------------------------------
// splice_site_kmer_max_score_unit
// Scores a nucleotide stream against a table of k-mer scores and reports
// the best window score per sequence.
// ----------------------------------------------------------------------------
module splice_site_kmer_max_score_unit
	import sskms_pkg::*;
#(
	parameter int WINDOW_LEN = 9,
	parameter int SCORE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	localparam int IDX_W = 2 * WINDOW_LEN;

	logic                  accept;
	logic                  hold;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [SCORE_BITS-1:0] wr_data;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic [SCORE_BITS-1:0] rd_data;
	s1_ctrl_t              ctrl_s1;

	assign item_stall = hold;
	assign accept     = item_valid && !item_stall;

	// front: decode, window shift, table access
	sskms_window #(
		.WINDOW_LEN(WINDOW_LEN),
		.SCORE_BITS(SCORE_BITS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.accept  (accept),
		.hold    (hold),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.ctrl_s1 (ctrl_s1)
	);

	// score table
	sskms_score_mem #(
		.ADDR_W(IDX_W),
		.DATA_W(SCORE_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// running max and output register
	sskms_max_track #(
		.SCORE_BITS(SCORE_BITS)
	) u_max (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl_s1      (ctrl_s1),
		.rd_data      (rd_data),
		.result_stall (result_stall),
		.hold         (hold),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

@@ hw/rtl/sskms_checker.sv @@
// ----------------------------------------------------------------------------
// sskms_checker
// Port-level checks on the splice site k-mer max score unit.
// ----------------------------------------------------------------------------
module sskms_checker
	import sskms_pkg::*;
#(
	parameter int SCORE_BITS = 16
) (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input in_item_t  item,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
	localparam logic [VALUE_W-1:0] EMPTY_SCORE = VALUE_W'(SCORE_MIN);

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
	else $error("result changed while stalled");

	// input backpressure only comes from a stalled full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
	else $error("item stall without stalled result");

	// a new result traces back to an accepted final base item
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |->
			$past(item_valid && !item_stall && item.command == CMD_BASE && item.last, 2))
	else $error("result without a final base item");

	// a short sequence reports the empty score
	a_empty_score: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.window_found |-> result.best_score == EMPTY_SCORE)
	else $error("short sequence with a score");

endmodule

bind splice_site_kmer_max_score_unit sskms_checker #(
	.SCORE_BITS(SCORE_BITS)
) u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

@@ bench/tb_splice_site_kmer_max_score_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_splice_site_kmer_max_score_unit
// Self-checking bench for the k-mer max score unit. Score loads and sequence
// bases are streamed in; an in-bench scoring model tracks the table, the
// 9-base window and the running maximum, and each result is compared with
// the oldest prediction. Every window lookup hits an entry written earlier.
// ----------------------------------------------------------------------------
module tb_splice_site_kmer_max_score_unit
	import sskms_pkg::*;
();

	localparam int KMER_LEN     = 9;
	localparam int WIN_W        = 2 * KMER_LEN;
	localparam int RANDOM_ITEMS = 890;
	localparam int HOLD_CYCLES  = 200;
	localparam int MAX_REPORTS  = 10;

	localparam logic signed [VALUE_W-1:0] SCORE_MIN = 16'sh8000;
	localparam logic signed [VALUE_W-1:0] SCORE_MAX = 16'sh7fff;
	localparam logic [CHAR_W-1:0]         CHAR_A    = 8'h41;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_stall;
	in_item_t  item         = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	splice_site_kmer_max_score_unit #(
		.WINDOW_LEN(KMER_LEN),
		.SCORE_BITS(VALUE_W)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #10 clk = ~clk;

	// Scoring model state
	bit signed [VALUE_W-1:0]     kmer_score [int];
	logic [WIN_W-1:0]            kmer_window  = '0;
	int                          bases_in_seq = 0;
	logic signed [VALUE_W-1:0]   best_so_far  = SCORE_MIN;
	bit                          seen_window  = 1'b0;
	out_item_t                   best_q [$];

	// Run statistics
	int items_sent         = 0;
	int seqs_sent          = 0;
	int short_seqs         = 0;
	int results_checked    = 0;
	int mismatches         = 0;
	int input_stall_cycles = 0;

	// Idle controls; result_gaps and hold_req are shared with the stall process
	bit item_gaps   = 1'b0;
	bit result_gaps = 1'b0;
	bit hold_req    = 1'b0;

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [1:0] code_of(input logic [CHAR_W-1:0] ch);
		if (ch == CHAR_C) return CODE_C;
		if (ch == CHAR_G) return CODE_G;
		if (ch == CHAR_T) return CODE_T;
		return CODE_OTHER;
	endfunction

	function automatic void clear_sequence();
		kmer_window  = '0;
		bases_in_seq = 0;
		best_so_far  = SCORE_MIN;
		seen_window  = 1'b0;
	endfunction

	// Update the model with one accepted item; a final base queues its result
	function automatic void score_item(input in_item_t it);
		logic signed [VALUE_W-1:0] s;
		out_item_t                 want;
		if (it.command == CMD_LOAD) begin
			kmer_score[int'(it.table_index)] = it.score_value;
			return;
		end
		kmer_window = {kmer_window[WIN_W-3:0], code_of(it.base_char)};
		if (bases_in_seq < KMER_LEN)
			bases_in_seq++;
		if (bases_in_seq >= KMER_LEN) begin
			s = kmer_score[int'(kmer_window)];
			if (s > best_so_far)
				best_so_far = s;
			seen_window = 1'b1;
		end
		if (it.last) begin
			want.best_score   = best_so_far;
			want.window_found = seen_window;
			best_q.push_back(want);
			clear_sequence();
		end
	endfunction

	function automatic logic signed [VALUE_W-1:0] rand_score();
		case ($urandom_range(0, 7))
			0:       return SCORE_MAX;
			1:       return SCORE_MIN;
			2:       return VALUE_W'($urandom_range(0, 3) * 256);  // frequent ties
			default: return VALUE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] rand_char();
		int r;
		r = $urandom_range(0, 19);
		if (r >= 16)
			return CHAR_W'($urandom_range(0, 255));
		case (r % 4)
			0:       return CHAR_A;
			1:       return CHAR_C;
			2:       return CHAR_G;
			default: return CHAR_T;
		endcase
	endfunction

	function automatic in_item_t load_item(input logic [INDEX_W-1:0] idx,
			input logic signed [VALUE_W-1:0] val);
		in_item_t it;
		it.command     = CMD_LOAD;
		it.table_index = idx;
		it.score_value = val;
		it.base_char   = CHAR_W'($urandom_range(0, 255));
		it.last        = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic in_item_t base_item(input logic [CHAR_W-1:0] ch, input bit fin);
		in_item_t it;
		it.command     = CMD_BASE;
		it.table_index = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
		it.score_value = VALUE_W'($urandom_range(0, 65535));
		it.base_char   = ch;
		it.last        = fin;
		return it;
	endfunction

	// Offer one item, wait for it to be taken, then maybe idle a while
	task automatic send_item(input in_item_t it);
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) begin
			input_stall_cycles++;
			@(posedge clk);
		end
		items_sent++;
		score_item(it);
		if (item_gaps && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// Send one base; a window that would hit an unwritten entry gets a load first
	task automatic send_base(input logic [CHAR_W-1:0] ch, input bit fin, input bit rewrite);
		logic [WIN_W-1:0] next_win;
		next_win = {kmer_window[WIN_W-3:0], code_of(ch)};
		if (bases_in_seq + 1 >= KMER_LEN &&
		    (!kmer_score.exists(int'(next_win)) || (rewrite && $urandom_range(0, 7) == 0)))
			send_item(load_item(next_win, rand_score()));
		send_item(base_item(ch, fin));
	endtask

	task automatic send_sequence(input int len);
		for (int i = 0; i < len; i++) begin
			// stray loads anywhere in the table
			if ($urandom_range(0, 15) == 0)
				send_item(load_item(INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1)),
					rand_score()));
			send_base(rand_char(), i == len - 1, 1'b1);
		end
		seqs_sent++;
		if (len < KMER_LEN)
			short_seqs++;
	endtask

	task automatic stop_items();
		item_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (best_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Extreme scores and indexes, short sequences, loads flagged last
	task automatic run_directed_cases();
		logic [CHAR_W-1:0] odd_chars [KMER_LEN];
		in_item_t          it;
		odd_chars = '{8'h00, 8'hff, CHAR_A, 8'h61, 8'h63, 8'h4e, 8'h80, 8'h42, 8'h44};
		item_gaps   = 1'b0;
		result_gaps = 1'b0;
		it = load_item('0, SCORE_MIN);
		it.last = 1'b1;
		send_item(it);
		it = load_item('1, SCORE_MAX);
		it.last = 1'b1;
		send_item(it);
		// single base, then one base short of a window: no window found
		send_base(CHAR_G, 1'b1, 1'b0);
		for (int i = 0; i < KMER_LEN - 1; i++)
			send_base(CHAR_T, i == KMER_LEN - 2, 1'b0);
		// A and non-ACGT bytes all map to code zero: lowest score, window found
		for (int i = 0; i < KMER_LEN; i++)
			send_base(odd_chars[i], i == KMER_LEN - 1, 1'b0);
		// all-T window: highest index, highest score
		for (int i = 0; i < KMER_LEN; i++)
			send_base(CHAR_T, i == KMER_LEN - 1, 1'b0);
		seqs_sent  += 4;
		short_seqs += 2;
		stop_items();
		wait_drained();
	endtask

	// Random sequences with random content and idle patterns that change per stretch
	task automatic run_random_streams();
		int start;
		int len;
		int r;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) == 0) begin
				item_gaps   = 1'($urandom_range(0, 1));
				result_gaps = 1'($urandom_range(0, 1));
			end
			r = $urandom_range(0, 9);
			if (r < 2)
				len = $urandom_range(1, KMER_LEN - 1);
			else if (r < 9)
				len = $urandom_range(KMER_LEN, 24);
			else
				len = $urandom_range(25, 60);
			send_sequence(len);
		end
		stop_items();
		wait_drained();
	endtask

	// Results held off for a long stretch while sequences of 1 to 12 bases keep coming
	task automatic run_output_hold_off();
		item_gaps   = 1'b0;
		result_gaps = 1'b0;
		hold_req    = 1'b1;
		for (int i = 0; i < 30; i++)
			send_sequence($urandom_range(1, 12));
		stop_items();
		wait_drained();
	endtask

	// Result side stall: random bursts, or one long hold-off on request
	initial begin : result_stall_drive
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
			end else if (result_gaps && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat (gap_len()) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (best_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result score %0d found %0b", $time,
						result.best_score, result.window_found);
			end else begin
				want = best_q.pop_front();
				results_checked++;
				if (result.best_score !== want.best_score ||
				    result.window_found !== want.window_found) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: mismatch, expected score %0d found %0b, got score %0d found %0b",
							$time, want.best_score, want.window_found,
							result.best_score, result.window_found);
				end
			end
		end
	end

	initial begin : watchdog
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin : main
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed_cases();
		run_random_streams();
		run_output_hold_off();
		$display("Sent %0d items in %0d sequences (%0d too short for a window), checked %0d results.",
			items_sent, seqs_sent, short_seqs, results_checked);
		$display("Input held by the block for %0d cycles under output back-pressure.",
			input_stall_cycles);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
